FILE: design/scaled_matrix_multiply_8ch_macros.svh
// Assertion macros used by smm_checker.
// Depends on nothing.
`ifndef SCALED_MATRIX_MULTIPLY_8CH_MACROS_SVH
`define SCALED_MATRIX_MULTIPLY_8CH_MACROS_SVH
`define SMM_ASSERT_IMP(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define SMM_ASSERT_NXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`endif

FILE: design/smm_pkg.sv
// Package: types and constants of the eight-channel scaled matrix multiply.
// Depends on nothing.
package smm_pkg;
  localparam int Channels = 8;
  localparam int InnerMaxDef = 32;
  localparam int ColumnsMaxDef = 64;
  localparam int ScaleDiv = 7 * 1024;
  localparam int SampleW = 16;
  localparam int CoefW = 16;
  localparam int AccW = 32;
  localparam int ResW = 20;
  localparam int ColW = 6;
  localparam int CfgIdxW = 1;
  localparam int CfgDataW = 7;
  localparam logic [CfgIdxW-1:0] RegInnerLength = 1'd0;
  localparam logic [CfgIdxW-1:0] RegOutputColumns = 1'd1;
  localparam logic CmdCoef = 1'b0;
  localparam logic CmdData = 1'b1;

  typedef logic [SampleW-1:0] sample_t;
  typedef logic signed [ResW-1:0] res_t;

  typedef struct packed {
    logic                cmd;
    logic [CoefW-1:0]    coef_value;
    sample_t [Channels-1:0] sample;
  } in_word_t;

  typedef struct packed {
    logic [ColW-1:0]     column_index;
    res_t [Channels-1:0] result;
    logic                last_of_row;
  } out_word_t;

  // 32-bit signed value over 7168, truncated toward zero:
  // magnitude >> 10, then /7 via reciprocal with one correction step.
  function automatic res_t scale_sum(input logic [AccW-1:0] acc);
    logic [AccW-1:0] mag;
    logic [21:0] m;
    logic [45:0] p;
    logic [21:0] q;
    logic [24:0] r;
    begin
      mag = acc[AccW-1] ? (~acc + 32'd1) : acc;
      m = mag[31:10];
      p = {24'd0, m} * 46'd599186;  // floor(2^22/7), quotient low by at most one
      q = p[43:22];
      r = {3'd0, m} - {q, 3'd0} + {3'd0, q};
      if (r >= 25'd7) q = q + 22'd1;
      scale_sum = acc[AccW-1] ? res_t'(~q + 22'd1) : res_t'(q);
    end
  endfunction
endpackage

FILE: design/smm_stream_if.sv
// Valid/ready stream interface carrying one word of type T.
// Depends on nothing; the word type is a parameter.
interface smm_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: design/smm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// Depends on nothing.
module smm_ram #(
  parameter int Width = 16,
  parameter int Depth = 2048,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [Width-1:0] wdata,
  input  logic [AddrW-1:0] raddr,
  output logic [Width-1:0] rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

FILE: design/scaled_matrix_multiply_8ch.sv
// Top level of the eight-channel scaled matrix multiply.
// Depends on smm_pkg, smm_stream_if and smm_ram.
// A data word walks the output columns one per cycle through a read-modify-write
// of the accumulator memory (all eight channels side by side in one entry); a
// row-completing word then streams one result per column, output port
// permitting. After reset, a clearing pass over all COLUMNS_MAX entries zeroes
// the accumulator memory before the first word is taken.
module scaled_matrix_multiply_8ch #(
  parameter int INNER_MAX = smm_pkg::InnerMaxDef,
  parameter int COLUMNS_MAX = smm_pkg::ColumnsMaxDef
) (
  input  logic clk,
  input  logic rst_n,
  smm_stream_if.sink   in_s,
  smm_stream_if.source out_s,
  input  logic                             cfg_we,
  input  logic [smm_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [smm_pkg::CfgDataW-1:0]     cfg_wdata
);
  localparam int Depth = INNER_MAX * COLUMNS_MAX;
  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = (COLUMNS_MAX > 1) ? $clog2(COLUMNS_MAX) : 1;
  localparam int CCW = $clog2(COLUMNS_MAX + 1);
  localparam int KW = $clog2(INNER_MAX + 1);
  localparam int AccRowW = smm_pkg::AccW * smm_pkg::Channels;

  localparam logic [2:0] StClr = 3'd0;
  localparam logic [2:0] StIdle = 3'd1;
  localparam logic [2:0] StMac = 3'd2;
  localparam logic [2:0] StOut = 3'd3;
  localparam logic [2:0] StOutW = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic [5:0] inner_r;
  logic [6:0] cols_r;
  logic [AW-1:0] wptr_r;
  logic [KW-1:0] kcnt_r;
  logic [CCW-1:0] ccnt_r;
  logic [CW-1:0] rcol_r, wcol_r;
  logic wb_r, last_rd_r;
  logic [AW-1:0] base_r;
  smm_pkg::sample_t [smm_pkg::Channels-1:0] smp_r;
  logic [CCW-1:0] eff_cols;
  logic [KW-1:0] eff_inner;
  logic [smm_pkg::CoefW-1:0] coef_rd;
  logic [AccRowW-1:0] acc_rd, acc_wd;
  logic acc_we;
  logic [CW-1:0] acc_waddr, acc_raddr;
  logic [AW-1:0] coef_raddr;
  logic in_acc;
  logic ovalid_r;
  smm_pkg::out_word_t odata_r;

  always_comb begin
    if (cols_r == 7'd0) eff_cols = CCW'(1);
    else if (32'(cols_r) > COLUMNS_MAX) eff_cols = CCW'(COLUMNS_MAX);
    else eff_cols = CCW'(cols_r);
    if (inner_r == 6'd0) eff_inner = KW'(1);
    else if (32'(inner_r) > INNER_MAX) eff_inner = KW'(INNER_MAX);
    else eff_inner = KW'(inner_r);
  end

  assign in_s.ready = (state_r == StIdle);
  assign in_acc = in_s.valid && in_s.ready;

  smm_ram #(.Width(smm_pkg::CoefW), .Depth(Depth)) u_coef (
    .clk(clk), .we(in_acc && in_s.data.cmd == smm_pkg::CmdCoef), .waddr(wptr_r),
    .wdata(in_s.data.coef_value), .raddr(coef_raddr), .rdata(coef_rd));

  smm_ram #(.Width(AccRowW), .Depth(COLUMNS_MAX)) u_acc (
    .clk(clk), .we(acc_we), .waddr(acc_waddr), .wdata(acc_wd),
    .raddr(acc_raddr), .rdata(acc_rd));

  // In the multiply-accumulate pass, reads and writes target different columns in flight; no forwarding needed.
  assign coef_raddr = AW'(32'(base_r) + 32'(rcol_r));
  assign acc_raddr = rcol_r;

  always_comb begin
    acc_we = 1'b0;
    acc_waddr = wcol_r;
    acc_wd = '0;
    if (state_r == StClr) begin
      acc_we = 1'b1;
      acc_waddr = rcol_r;
    end else if (wb_r) begin
      acc_we = 1'b1;
      for (int ch = 0; ch < smm_pkg::Channels; ch++)
        acc_wd[ch*smm_pkg::AccW +: smm_pkg::AccW] =
          acc_rd[ch*smm_pkg::AccW +: smm_pkg::AccW] + smp_r[ch] * coef_rd;
    end else if ((state_r == StOutW) && (!ovalid_r || out_s.ready)) begin
      acc_we = 1'b1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      StClr: if (32'(rcol_r) == COLUMNS_MAX - 1) state_nxt = StIdle;
      StIdle: if (in_acc && in_s.data.cmd == smm_pkg::CmdData) state_nxt = StMac;
      StMac: if (wb_r && last_rd_r)
               state_nxt = (kcnt_r >= eff_inner) ? StOut : StIdle;
      StOut: state_nxt = StOutW;
      StOutW: if (!ovalid_r || out_s.ready)
                state_nxt = (32'(wcol_r) + 1 == 32'(eff_cols)) ? StIdle : StOut;
      default: state_nxt = StIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= StClr;
      inner_r <= 6'd32;
      cols_r <= 7'd64;
      wptr_r <= '0;
      kcnt_r <= '0;
      ccnt_r <= '0;
      rcol_r <= '0;
      wcol_r <= '0;
      wb_r <= 1'b0;
      last_rd_r <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we && cfg_index == smm_pkg::RegInnerLength) inner_r <= cfg_wdata[5:0];
      if (cfg_we && cfg_index == smm_pkg::RegOutputColumns) cols_r <= cfg_wdata;
      if (out_s.ready && state_r != StOutW) ovalid_r <= 1'b0;
      wb_r <= (state_r == StMac) && (ccnt_r < eff_cols);
      unique case (state_r)
        StClr: rcol_r <= rcol_r + CW'(1);
        StIdle: begin
          rcol_r <= '0;
          ccnt_r <= '0;
          if (in_acc && in_s.data.cmd == smm_pkg::CmdCoef)
            wptr_r <= (32'(wptr_r) == Depth - 1) ? '0 : wptr_r + AW'(1);
          if (in_acc && in_s.data.cmd == smm_pkg::CmdData) begin
            smp_r <= in_s.data.sample;
            base_r <= AW'(32'(kcnt_r) * 32'(eff_cols));
            kcnt_r <= kcnt_r + KW'(1);
          end
        end
        StMac: begin
          if (ccnt_r < eff_cols) begin
            wcol_r <= rcol_r;
            last_rd_r <= (ccnt_r + CCW'(1) == eff_cols);
            rcol_r <= rcol_r + CW'(1);
            ccnt_r <= ccnt_r + CCW'(1);
          end
          if (wb_r && last_rd_r) begin
            rcol_r <= '0;
            wcol_r <= '0;
            if (kcnt_r >= eff_inner) kcnt_r <= '0;
          end
        end
        StOut: ;
        StOutW: begin
          if (!ovalid_r || out_s.ready) begin
            ovalid_r <= 1'b1;
            odata_r.column_index <= smm_pkg::ColW'(rcol_r);
            for (int ch = 0; ch < smm_pkg::Channels; ch++)
              odata_r.result[ch] <=
                smm_pkg::scale_sum(acc_rd[ch*smm_pkg::AccW +: smm_pkg::AccW]);
            odata_r.last_of_row <= (32'(rcol_r) + 1 == 32'(eff_cols));
            wcol_r <= rcol_r + CW'(1);
            rcol_r <= rcol_r + CW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // StOutW writes zero to the column just shown; acc_waddr must be rcol_r then.
  assign out_s.valid = ovalid_r;
  assign out_s.data = odata_r;
endmodule

FILE: design/smm_checker.sv
// Port-level checker for scaled_matrix_multiply_8ch, bound to the top level.
// Depends on smm_pkg and the macro header.
`include "scaled_matrix_multiply_8ch_macros.svh"
module smm_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [smm_pkg::ColW-1:0] out_col,
  input logic out_last
);
  `SMM_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  `SMM_ASSERT_NXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_col) && $stable(out_last))
  `SMM_ASSERT_NXT(a_in_hold, clk, rst_n, in_valid && !in_ready, in_valid)
  `SMM_ASSERT_NXT(a_col_restart, clk, rst_n, out_valid && out_ready && out_last,
    !out_valid || out_col == '0)
endmodule

bind scaled_matrix_multiply_8ch smm_checker u_smm_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_s.valid), .in_ready(in_s.ready),
  .out_valid(out_s.valid), .out_ready(out_s.ready),
  .out_col(out_s.data.column_index), .out_last(out_s.data.last_of_row));
